>>> rtl/core/mtw_pkg.sv
// ---------------------------------------------------------------------------
// mtw_pkg: shared types and constants of the MT19937 word generator
// Algorithm constants, controller state encoding and the command/status
// bundles that join the controller and the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package mtw_pkg;

	localparam int unsigned STATE_DEPTH   = 624;
	localparam int unsigned MIDDLE_OFFSET = 397;

	localparam logic [31:0] TWIST_MATRIX  = 32'h9908_b0df;
	localparam logic [31:0] TEMPER_MASK_B = 32'h9d2c_5680;
	localparam logic [31:0] TEMPER_MASK_C = 32'hefc6_0000;
	localparam logic [31:0] INIT_MULT     = 32'd1812433253;

	typedef enum logic [3:0] {
		ST_BOOT,
		ST_IDLE,
		ST_GEN_RD,
		ST_GEN_OUT,
		ST_TW_FIRST,
		ST_TW_LOAD,
		ST_TW_RD,
		ST_TW_WR,
		ST_FILL_MUL,
		ST_FILL_WR
	} state_t;

	typedef struct packed {
		logic seed_load;   // write word 0 from the seed, start the fill
		logic seed_zero;   // seed is zero (reset) instead of the request field
		logic fill_mul;    // multiply step of the init recurrence
		logic fill_write;  // add index and store the next init word
		logic rd_first;    // read word 0 ahead of the twist
		logic cur_load;    // latch word 0 as the current twist word
		logic rd_twist;    // read next and middle words
		logic tw_write;    // store one twisted word
		logic rd_gen;      // read word at the read position
		logic out_load;    // temper into the output register
	} dp_cmd_t;

	typedef struct packed {
		logic pos_end;     // read position has reached the depth
		logic k_last;      // sweep counter is at the last entry
		logic out_free;    // output register can take a word this cycle
	} dp_status_t;

	function automatic logic [31:0] temper(input logic [31:0] y_in);
		logic [31:0] y;
		y = y_in;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & TEMPER_MASK_B);
		y = y ^ ((y << 15) & TEMPER_MASK_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/mtw_if.sv
// ---------------------------------------------------------------------------
// mtw_if: channel interfaces of the MT19937 word generator
// Request channel (command, seed) and result channel (random word).
// ---------------------------------------------------------------------------
`default_nettype none

interface mtw_req_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [31:0] seed_value;

	modport source (output valid, output command, output seed_value, input ready);
	modport sink (input valid, input command, input seed_value, output ready);
endinterface

interface mtw_res_if;
	logic        valid;
	logic        ready;
	logic [31:0] random_word;

	modport source (output valid, output random_word, input ready);
	modport sink (input valid, input random_word, output ready);
endinterface

`default_nettype wire

>>> rtl/core/mtw_datapath.sv
// ---------------------------------------------------------------------------
// mtw_datapath: state memory and arithmetic of the MT19937 generator
// 624-word state RAM (one write, two registered reads), init multiplier,
// twist and temper logic, sweep counter, read position and output register.
// ---------------------------------------------------------------------------
`default_nettype none

module mtw_datapath #(
	parameter int unsigned STATE_DEPTH   = mtw_pkg::STATE_DEPTH,
	parameter int unsigned MIDDLE_OFFSET = mtw_pkg::MIDDLE_OFFSET
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire mtw_pkg::dp_cmd_t    cmd,
	input  wire logic [31:0]         seed_value,
	output mtw_pkg::dp_status_t      status,
	output logic                     res_valid,
	input  wire logic                res_ready,
	output logic [31:0]              random_word
);

	localparam int unsigned AW = $clog2(STATE_DEPTH);
	localparam int unsigned PW = $clog2(STATE_DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(STATE_DEPTH - 1);
	localparam logic [AW:0]   MID_OFS  = (AW+1)'(MIDDLE_OFFSET);
	localparam logic [AW:0]   DEPTH_X  = (AW+1)'(STATE_DEPTH);
	localparam logic [PW-1:0] POS_END  = PW'(STATE_DEPTH);

	logic [31:0] mem [0:STATE_DEPTH-1];

	logic [AW-1:0] k_q;
	logic [PW-1:0] pos_q;
	logic          res_valid_q;
	logic [31:0]   rd0_q, rd1_q, cur_q, prev_q, prod_q, word_q;

	logic [AW-1:0] nxt_addr, mid_addr, rd0_addr;
	logic [AW:0]   mid_sum;
	logic          rd0_en;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [31:0]   wr_data;
	logic [31:0]   seed_word, mixed, fill_word, joined, shifted, twist_word;

	assign nxt_addr = (k_q == LAST_IDX) ? '0 : k_q + 1'b1;
	assign mid_sum  = {1'b0, k_q} + MID_OFS;
	assign mid_addr = (mid_sum >= DEPTH_X) ? AW'(mid_sum - DEPTH_X) : mid_sum[AW-1:0];

	assign rd0_en = cmd.rd_gen | cmd.rd_first | cmd.rd_twist;

	always_comb begin
		if (cmd.rd_gen) begin
			rd0_addr = pos_q[AW-1:0];
		end else if (cmd.rd_first) begin
			rd0_addr = '0;
		end else begin
			rd0_addr = nxt_addr;
		end
	end

	assign seed_word = cmd.seed_zero ? 32'd0 : seed_value;
	assign mixed     = prev_q ^ (prev_q >> 30);
	assign fill_word = prod_q + 32'(k_q);

	// upper bit of the current word, lower bits of the next one
	assign joined     = {cur_q[31], rd0_q[30:0]};
	assign shifted    = (joined >> 1) ^ (joined[0] ? mtw_pkg::TWIST_MATRIX : 32'd0);
	assign twist_word = rd1_q ^ shifted;

	always_comb begin
		wr_en   = cmd.seed_load | cmd.tw_write | cmd.fill_write;
		wr_addr = k_q;
		wr_data = fill_word;
		if (cmd.seed_load) begin
			wr_addr = '0;
			wr_data = seed_word;
		end else if (cmd.tw_write) begin
			wr_data = twist_word;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd0_en) begin
			rd0_q <= mem[rd0_addr];
		end
		if (cmd.rd_twist) begin
			rd1_q <= mem[mid_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.seed_load) begin
			prev_q <= seed_word;
		end else if (cmd.fill_write) begin
			prev_q <= fill_word;
		end
		if (cmd.fill_mul) begin
			prod_q <= mixed * mtw_pkg::INIT_MULT;
		end
		if (cmd.cur_load || cmd.tw_write) begin
			cur_q <= rd0_q;
		end
		if (cmd.out_load) begin
			word_q <= mtw_pkg::temper(rd0_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			pos_q       <= POS_END;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.seed_load) begin
				k_q   <= AW'(1);
				pos_q <= POS_END;
			end else if (cmd.rd_first) begin
				k_q <= '0;
			end else if (cmd.tw_write || cmd.fill_write) begin
				k_q <= nxt_addr;
				if (k_q == LAST_IDX) begin
					pos_q <= cmd.tw_write ? '0 : POS_END;
				end
			end else if (cmd.out_load) begin
				pos_q <= pos_q + 1'b1;
			end

			if (cmd.out_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign status.pos_end  = (pos_q == POS_END);
	assign status.k_last   = (k_q == LAST_IDX);
	assign status.out_free = !res_valid_q || res_ready;

	assign res_valid   = res_valid_q;
	assign random_word = word_q;

endmodule

`default_nettype wire

>>> rtl/core/mtw_ctrl.sv
// ---------------------------------------------------------------------------
// mtw_ctrl: sequencer of the MT19937 generator
// Walks the seed fill, the state twist and the word read, one datapath
// command set per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module mtw_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	input  wire logic                req_command,
	output logic                     req_ready,
	output mtw_pkg::dp_cmd_t         cmd,
	input  wire mtw_pkg::dp_status_t status
);

	mtw_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mtw_pkg::ST_BOOT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			mtw_pkg::ST_BOOT: begin
				// reset behaves as a seed of zero
				cmd.seed_load = 1'b1;
				cmd.seed_zero = 1'b1;
				state_d       = mtw_pkg::ST_FILL_MUL;
			end
			mtw_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					if (req_command) begin
						cmd.seed_load = 1'b1;
						state_d       = mtw_pkg::ST_FILL_MUL;
					end else if (status.pos_end) begin
						state_d = mtw_pkg::ST_TW_FIRST;
					end else begin
						state_d = mtw_pkg::ST_GEN_RD;
					end
				end
			end
			mtw_pkg::ST_GEN_RD: begin
				cmd.rd_gen = 1'b1;
				state_d    = mtw_pkg::ST_GEN_OUT;
			end
			mtw_pkg::ST_GEN_OUT: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = mtw_pkg::ST_IDLE;
				end
			end
			mtw_pkg::ST_TW_FIRST: begin
				cmd.rd_first = 1'b1;
				state_d      = mtw_pkg::ST_TW_LOAD;
			end
			mtw_pkg::ST_TW_LOAD: begin
				cmd.cur_load = 1'b1;
				state_d      = mtw_pkg::ST_TW_RD;
			end
			mtw_pkg::ST_TW_RD: begin
				cmd.rd_twist = 1'b1;
				state_d      = mtw_pkg::ST_TW_WR;
			end
			mtw_pkg::ST_TW_WR: begin
				cmd.tw_write = 1'b1;
				state_d      = status.k_last ? mtw_pkg::ST_GEN_RD : mtw_pkg::ST_TW_RD;
			end
			mtw_pkg::ST_FILL_MUL: begin
				cmd.fill_mul = 1'b1;
				state_d      = mtw_pkg::ST_FILL_WR;
			end
			mtw_pkg::ST_FILL_WR: begin
				cmd.fill_write = 1'b1;
				state_d        = status.k_last ? mtw_pkg::ST_IDLE : mtw_pkg::ST_FILL_MUL;
			end
			default: begin
				state_d = mtw_pkg::ST_BOOT;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/core/mt19937_word_generator.sv
// ---------------------------------------------------------------------------
// mt19937_word_generator: 32-bit Mersenne Twister word source
// Seed requests refill the state; generate requests return a tempered word.
// ---------------------------------------------------------------------------
//  channel | dir | fields                | notes
//  req     | in  | command, seed_value   | 0 = generate, 1 = reseed
//  res     | out | random_word           | one word per generate request
//
//  Generate: the RAM read lands in a register, then the temper loads the output
//  register. When the read position reaches 624, the twist runs first: a read
//  step and a write step per entry through the two-read-port state RAM.
//  Reseed: a multiply step and a write step per word through the init multiplier.
//  After reset the same fill runs with seed 0 (req.ready low throughout).
//  A stalled result holds in the output register; the next request is taken
//  meanwhile, and a generate waits only at its own output load.
// ---------------------------------------------------------------------------
`default_nettype none

module mt19937_word_generator #(
	parameter int unsigned STATE_DEPTH   = mtw_pkg::STATE_DEPTH,
	parameter int unsigned MIDDLE_OFFSET = mtw_pkg::MIDDLE_OFFSET
) (
	input  wire logic clk,
	input  wire logic arst_n,
	mtw_req_if.sink   req,
	mtw_res_if.source res
);

	mtw_pkg::dp_cmd_t    cmd;
	mtw_pkg::dp_status_t status;

	mtw_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req.valid),
		.req_command (req.command),
		.req_ready   (req.ready),
		.cmd         (cmd),
		.status      (status)
	);

	mtw_datapath #(
		.STATE_DEPTH   (STATE_DEPTH),
		.MIDDLE_OFFSET (MIDDLE_OFFSET)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.seed_value  (req.seed_value),
		.status      (status),
		.res_valid   (res.valid),
		.res_ready   (res.ready),
		.random_word (res.random_word)
	);

endmodule

`default_nettype wire

>>> rtl/core/mtw_checker.sv
// ---------------------------------------------------------------------------
// mtw_checker: port-level checks of the MT19937 word generator
// Watches the request and result channels; bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module mtw_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_valid,
	input wire logic        req_ready,
	input wire logic        req_command,
	input wire logic        res_valid,
	input wire logic        res_ready,
	input wire logic [31:0] random_word
);

	logic req_acc;
	assign req_acc = req_valid && req_ready;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	a_word_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(random_word))
		else $error("result word changed while stalled");

	// seed fill and word read both keep the request side busy
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> !req_ready)
		else $error("request taken while previous request still in work");

	a_seed_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && req_command |=> ##1 !req_ready)
		else $error("seed fill ended too early");

	a_word_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(!req_ready))
		else $error("result appeared without a generate in work");

endmodule

bind mt19937_word_generator mtw_checker u_mtw_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.req_command (req.command),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.random_word (res.random_word)
);

`default_nettype wire

>>> bench/mtw_test_pkg.sv
// ---------------------------------------------------------------------------
// mtw_test_pkg: request codes shared by the word generator bench
// Command encoding of the request channel, used by stimulus and checker.
// ---------------------------------------------------------------------------
package mtw_test_pkg;

	localparam logic CMD_GENERATE = 1'b0;
	localparam logic CMD_RESEED   = 1'b1;

endpackage

>>> bench/mt19937_word_checker.sv
// ---------------------------------------------------------------------------
// mt19937_word_checker: predicts and checks the generator's output words
// Watches both channels, runs its own MT19937 state on every accepted
// request and compares each accepted word against the oldest prediction.
// ---------------------------------------------------------------------------
module mt19937_word_checker (
	input  logic clk,
	input  logic arst_n,
	mtw_req_if   req,
	mtw_res_if   res,
	output int   mismatches,
	output int   due_count,
	output int   words_checked,
	output int   reseeds,
	output int   twists
);
	import mtw_pkg::*;
	import mtw_test_pkg::*;

	logic [31:0] twister_mt [STATE_DEPTH];
	int unsigned word_ptr;
	logic [31:0] words_due [$];
	logic [31:0] want;

	function automatic void load_seed(input logic [31:0] seed);
		logic [31:0] prev;
		twister_mt[0] = seed;
		for (int k = 1; k < STATE_DEPTH; k++) begin
			prev = twister_mt[k - 1];
			twister_mt[k] = INIT_MULT * (prev ^ (prev >> 30)) + 32'(k);
		end
		word_ptr = STATE_DEPTH;
	endfunction

	// in-place sweep: late entries see already twisted neighbors, as the algorithm requires
	function automatic void twist_all();
		int unsigned nxt;
		int unsigned mid;
		logic [31:0] joined;
		logic [31:0] shifted;
		for (int unsigned k = 0; k < STATE_DEPTH; k++) begin
			nxt = (k + 1) % STATE_DEPTH;
			mid = (k + MIDDLE_OFFSET) % STATE_DEPTH;
			joined = {twister_mt[k][31], twister_mt[nxt][30:0]};
			shifted = joined >> 1;
			if (joined[0])
				shifted = shifted ^ TWIST_MATRIX;
			twister_mt[k] = twister_mt[mid] ^ shifted;
		end
		word_ptr = 0;
		twists = twists + 1;
	endfunction

	function automatic logic [31:0] tempered(input logic [31:0] raw);
		logic [31:0] t;
		t = raw ^ (raw >> 11);
		t = t ^ ((t << 7) & TEMPER_MASK_B);
		t = t ^ ((t << 15) & TEMPER_MASK_C);
		return t ^ (t >> 18);
	endfunction

	function automatic logic [31:0] next_word();
		logic [31:0] w;
		if (word_ptr >= STATE_DEPTH)
			twist_all();
		w = tempered(twister_mt[word_ptr]);
		word_ptr = word_ptr + 1;
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_due.delete();
			twists = 0;
			load_seed(32'd0);
			mismatches <= 0;
			due_count <= 0;
			words_checked <= 0;
			reseeds <= 0;
		end else begin
			if (res.valid && res.ready) begin
				if (words_due.size() == 0) begin
					$error("random_word %h arrived with no generate request outstanding",
						res.random_word);
					mismatches <= mismatches + 1;
				end else begin
					want = words_due.pop_front();
					if (res.random_word !== want) begin
						$error("random_word mismatch: expected %h, actual %h",
							want, res.random_word);
						mismatches <= mismatches + 1;
					end
					words_checked <= words_checked + 1;
				end
			end
			if (req.valid && req.ready) begin
				if (req.command == CMD_RESEED) begin
					load_seed(req.seed_value);
					reseeds <= reseeds + 1;
				end else begin
					words_due.push_back(next_word());
				end
			end
			due_count <= words_due.size();
		end
	end

endmodule

>>> bench/mt19937_word_generator_test.sv
// ---------------------------------------------------------------------------
// mt19937_word_generator_test: top of the MT19937 word generator bench
// Drives reseed and generate requests with random pacing and back-pressure;
// a checker beside the block predicts every word and counts failures.
// ---------------------------------------------------------------------------
module mt19937_word_generator_test;
	import mtw_test_pkg::*;

	localparam int CYCLE_LIMIT  = 1500000;
	localparam int LONG_HOLD    = 300;
	localparam int LONG_RUN     = 700;
	localparam int REQUEST_GOAL = 1425;
	localparam int DRAIN_TAIL   = 2600;

	logic clk = 1'b0;
	logic arst_n;
	int   cycle_count = 0;
	int   sent = 0;
	bit   sender_steady;
	bit   sink_steady;
	bit   long_hold_due;

	int mismatches;
	int due_count;
	int words_checked;
	int reseeds;
	int twists;

	mtw_req_if req_ch ();
	mtw_res_if res_ch ();

	mt19937_word_generator DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.res   (res_ch)
	);

	mt19937_word_checker word_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req_ch),
		.res          (res_ch),
		.mismatches   (mismatches),
		.due_count    (due_count),
		.words_checked(words_checked),
		.reseeds      (reseeds),
		.twists       (twists)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still due", cycle_count, due_count);
			$display("mt19937_word_generator test failed");
			$finish;
		end
	end

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(15, 60);
	endfunction

	task automatic offer(input logic cmd, input logic [31:0] seed);
		int gap;
		req_ch.valid <= 1'b1;
		req_ch.command <= cmd;
		req_ch.seed_value <= seed;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		sent++;
		gap = sender_steady ? 0 : pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			req_ch.command <= 1'($urandom);
			req_ch.seed_value <= $urandom;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (due_count != 0);
	endtask

	// result side pacing, including the one long hold-off
	initial begin
		int stall;
		stall = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_due) begin
				long_hold_due = 1'b0;
				res_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (stall > 0) begin
				res_ch.ready <= 1'b0;
				stall--;
			end else if (sink_steady) begin
				res_ch.ready <= 1'b1;
			end else begin
				stall = pick_gap();
				res_ch.ready <= (stall == 0);
				if (stall > 0)
					stall--;
			end
		end
	end

	initial begin
		logic [31:0] seed;
		int run;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.command <= CMD_GENERATE;
		req_ch.seed_value <= 32'd0;
		sender_steady = 1'b0;
		sink_steady = 1'b0;
		long_hold_due = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// state seeded with zero by reset; first request twists
		offer(CMD_GENERATE, 32'd0);
		offer(CMD_GENERATE, 32'hffff_ffff);
		offer(CMD_GENERATE, $urandom);
		offer(CMD_RESEED, 32'd5489);
		offer(CMD_GENERATE, 32'd0);
		offer(CMD_GENERATE, 32'd0);
		offer(CMD_RESEED, 32'hffff_ffff);
		offer(CMD_GENERATE, 32'd0);
		// reseed right after reseed, no word in between
		offer(CMD_RESEED, 32'd0);
		offer(CMD_RESEED, 32'd1);
		offer(CMD_GENERATE, 32'hffff_ffff);
		offer(CMD_RESEED, 32'h8000_0000);
		offer(CMD_GENERATE, 32'hffff_ffff);
		offer(CMD_GENERATE, $urandom);

		// one long stream from a single seed crosses the 624-word boundary
		offer(CMD_RESEED, $urandom);
		for (int i = 0; i < LONG_RUN; i++) begin
			if (i == 250) begin
				long_hold_due = 1'b1;
				sender_steady = 1'b1;
			end
			if (i == 290)
				sender_steady = 1'b0;
			if (i == 420) begin
				sender_steady = 1'b1;
				sink_steady = 1'b1;
			end
			if (i == 520) begin
				sender_steady = 1'b0;
				sink_steady = 1'b0;
			end
			offer(CMD_GENERATE, $urandom);
		end
		req_ch.valid <= 1'b0;
		wait_drained();

		// short seeded streams with mixed pacing
		while (sent < REQUEST_GOAL) begin
			sender_steady = ($urandom_range(0, 3) == 0);
			sink_steady = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 7))
				0: seed = 32'd0;
				1: seed = 32'hffff_ffff;
				2: seed = 32'd1 << $urandom_range(0, 31);
				default: seed = $urandom;
			endcase
			offer(CMD_RESEED, seed);
			if ($urandom_range(0, 7) == 0)
				offer(CMD_RESEED, $urandom);
			run = $urandom_range(1, 60);
			repeat (run) offer(CMD_GENERATE, $urandom);
		end

		req_ch.valid <= 1'b0;
		wait_drained();
		repeat (DRAIN_TAIL) @(posedge clk);

		$display("Ran %0d requests: %0d reseeds, %0d words checked, %0d state regenerations",
			sent, reseeds, words_checked, twists);
		$display("Pacing: random gaps both sides, one long output stall, one full drain pause");
		if (mismatches == 0)
			$display("mt19937_word_generator test passed");
		else
			$display("mt19937_word_generator test failed");
		$finish;
	end

endmodule
